// File: rtl/phb_pkg.sv
// shared types, constants and reset table of the host bridge config space
`timescale 1ns / 1ps
package phb_pkg;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_RESET = 2'd2
   } phb_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SECOND
   } phb_state_type;

   localparam logic [7:0] OFF_CMD_LO   = 8'h04;
   localparam logic [7:0] OFF_CMD_HI   = 8'h05;
   localparam logic [7:0] OFF_STS_LO   = 8'h06;
   localparam logic [7:0] OFF_STS_HI   = 8'h07;
   localparam logic [7:0] OFF_BAR_LO   = 8'h10;
   localparam logic [7:0] OFF_BAR_END  = 8'h4f;
   localparam logic [7:0] OFF_PAM0     = 8'h59;
   localparam logic [7:0] OFF_PAM1     = 8'h5a;
   localparam logic [7:0] OFF_PAM2     = 8'h5b;
   localparam logic [7:0] OFF_PAM6     = 8'h5f;

   localparam logic [7:0] CMD_KEEP     = 8'h42;
   localparam logic [7:0] CMD_FORCE    = 8'h04;
   localparam logic [7:0] CMD_HI_KEEP  = 8'h01;
   localparam logic [7:0] STS_HI_FORCE = 8'h02;
   localparam logic [7:0] OTHER_FUNC   = 8'hff;

   localparam logic [19:0] BIOS_BASE   = 20'hf0000;
   localparam logic [19:0] ROM_BASE    = 20'hc0000;
   localparam logic [19:0] HALF_STEP   = 20'h04000;
   localparam logic [16:0] SIZE_64K    = 17'h10000;
   localparam logic [16:0] SIZE_16K    = 17'h04000;

   typedef struct packed {
      logic [19:0] base;
      logic [16:0] size;
      logic        rd_int;
      logic        wr_int;
   } phb_seg_type;

   typedef struct packed {
      logic        we;
      logic [7:0]  data;
      logic [1:0]  count;
      phb_seg_type seg0;
      phb_seg_type seg1;
      logic        shadow_we;
      logic        shadow_val;
   } phb_wr_type;

   function automatic logic [7:0] phb_reset_byte(input logic variant, input logic [7:0] addr);
      logic [7:0] v;
      v = 8'h00;
      case (addr)
         8'h00: v = 8'h86;
         8'h01: v = 8'h80;
         8'h02: v = 8'ha3;
         8'h03: v = 8'h04;
         8'h04: v = 8'h06;
         8'h07: v = 8'h02;
         8'h0b: v = 8'h06;
         8'h57: v = 8'h31;
         8'h60, 8'h61, 8'h62, 8'h63, 8'h64: v = 8'h02;
         8'h08: v = variant ? 8'h10 : 8'h03;
         8'h50: v = variant ? 8'ha0 : 8'h80;
         8'h52: v = variant ? 8'h44 : 8'h40;
         8'h66, 8'h67: v = variant ? 8'h02 : 8'h00;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/phb_cfg_mem.sv
// config byte memory with registered read and per-entry reset defaults
`timescale 1ns / 1ps
module phb_cfg_mem #(
   parameter int CHIP_VARIANT = 0,
   parameter int DEPTH        = 256,
   parameter int AW           = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data
);
   import phb_pkg::*;

   logic [7:0]       ram_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [7:0]       rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (valid_ff[rd_addr]) begin
            rd_data_ff <= ram_ff[rd_addr];
         end else begin
            rd_data_ff <= phb_reset_byte(CHIP_VARIANT != 0, 8'(rd_addr));
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/phb_wr_filter.sv
// write masking and PAM segment change decode
`timescale 1ns / 1ps
module phb_wr_filter (
   input  logic               [7:0] addr,
   input  logic               [7:0] old_val,
   input  logic               [7:0] new_val,
   input  logic                     pam2_en,
   output phb_pkg::phb_wr_type      wr
);
   import phb_pkg::*;

   logic        drop;
   logic [7:0]  diff;
   logic [2:0]  idx;
   logic [19:0] lo_base;
   phb_seg_type lo_seg;
   phb_seg_type hi_seg;
   logic        pam_x;

   assign diff    = old_val ^ new_val;
   assign idx     = 3'(addr - OFF_PAM1);
   assign lo_base = ROM_BASE + 20'({idx, 15'b0});
   assign pam_x   = (addr >= OFF_PAM1) && (addr <= OFF_PAM6) && ((addr != OFF_PAM2) || pam2_en);

   always_comb begin
      lo_seg.base   = lo_base;
      lo_seg.size   = SIZE_16K;
      lo_seg.rd_int = new_val[0];
      lo_seg.wr_int = new_val[1];
      hi_seg.base   = lo_base + HALF_STEP;
      hi_seg.size   = SIZE_16K;
      hi_seg.rd_int = new_val[4];
      hi_seg.wr_int = new_val[5];
   end

   always_comb begin
      drop = (addr >= OFF_BAR_LO) && (addr < OFF_BAR_END);
      case (addr)
         8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0e: drop = 1'b1;
         default: ;
      endcase

      wr            = '0;
      wr.we         = !drop;
      wr.data       = new_val;
      case (addr)
         OFF_CMD_LO: wr.data = (new_val & CMD_KEEP) | CMD_FORCE;
         OFF_CMD_HI: wr.data = new_val & CMD_HI_KEEP;
         OFF_STS_LO: wr.data = 8'h00;
         OFF_STS_HI: wr.data = STS_HI_FORCE;
         default: ;
      endcase

      if (addr == OFF_PAM0) begin
         if (diff[7:4] != 4'h0) begin
            wr.count       = 2'd1;
            wr.seg0.base   = BIOS_BASE;
            wr.seg0.size   = SIZE_64K;
            wr.seg0.rd_int = new_val[4];
            wr.seg0.wr_int = new_val[5];
            wr.shadow_we   = 1'b1;
            wr.shadow_val  = new_val[4];
         end
      end else if (pam_x) begin
         if (diff[3:0] != 4'h0) begin
            wr.seg0 = lo_seg;
            wr.seg1 = hi_seg;
            wr.count = (diff[7:4] != 4'h0) ? 2'd2 : 2'd1;
         end else if (diff[7:4] != 4'h0) begin
            wr.seg0  = hi_seg;
            wr.count = 2'd1;
         end
      end
   end

endmodule

// File: rtl/pci_host_bridge_pam_config.sv
// top level: host bridge config space with PAM segment updates
`timescale 1ns / 1ps
// A request reads the config byte from the memory in the cycle its request
// beat is taken; a write modifies the byte and writes it back in the LOOK
// state, when the first response beat is loaded. A PAM write that changes
// both nibbles of a segment register adds the SECOND state for its second
// response beat; a stalled response holds the block in place. The
// memory's reset contents come from per-byte valid flags cleared by reset,
// so requests are taken right after reset with no fill pass. A command value
// of 3 is taken and gives no response.
module pci_host_bridge_pam_config #(
   parameter int CHIP_VARIANT = 0,
   parameter int SPACE_BYTES  = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_function_number,
   input  logic [7:0]  req_reg_offset,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_map_update,
   output logic [19:0] rsp_segment_base,
   output logic [16:0] rsp_segment_size,
   output logic        rsp_read_internal,
   output logic        rsp_write_internal,
   output logic        rsp_shadow_bios,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_pam2_enable
);
   import phb_pkg::*;

   localparam int AW = $clog2(SPACE_BYTES);

   phb_state_type state_ff, state_in;
   logic        is_read_ff, is_read_in;
   logic        func_zero_ff, func_zero_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;
   logic        pam2_ff, pam2_in;
   logic        shadow_ff, shadow_in;
   phb_seg_type pend_ff, pend_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_rd_ff, rsp_rd_in;
   logic        rsp_mu_ff, rsp_mu_in;
   phb_seg_type rsp_seg_ff, rsp_seg_in;
   logic        rsp_shadow_ff, rsp_shadow_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        req_take;
   logic        out_free;
   logic        mem_re;
   logic        mem_we;
   logic [7:0]  rd_addr;
   logic [7:0]  mem_rdata;
   phb_wr_type  wr;
   phb_cmd_type cmd;

   assign cmd       = phb_cmd_type'(req_command);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rd_addr   = (cmd == CMD_RESET) ? OFF_PAM0 : req_reg_offset;
   assign mem_re    = req_take;
   assign mem_we    = (state_ff == ST_LOOK) && out_free && !is_read_ff && func_zero_ff && wr.we;

   phb_cfg_mem #(
      .CHIP_VARIANT (CHIP_VARIANT),
      .DEPTH        (SPACE_BYTES)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_re),
      .rd_addr (rd_addr[AW-1:0]),
      .rd_data (mem_rdata),
      .wr_en   (mem_we),
      .wr_addr (addr_ff[AW-1:0]),
      .wr_data (wr.data)
   );

   phb_wr_filter u_filter (
      .addr    (addr_ff),
      .old_val (mem_rdata),
      .new_val (data_ff),
      .pam2_en (pam2_ff),
      .wr      (wr)
   );

   always_comb begin
      state_in      = state_ff;
      is_read_in    = is_read_ff;
      func_zero_in  = func_zero_ff;
      addr_in       = addr_ff;
      data_in       = data_ff;
      pam2_in       = (csr_valid && csr_ready) ? csr_pam2_enable : pam2_ff;
      shadow_in     = shadow_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_rd_in     = rsp_rd_ff;
      rsp_mu_in     = rsp_mu_ff;
      rsp_seg_in    = rsp_seg_ff;
      rsp_shadow_in = rsp_shadow_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               addr_in      = rd_addr;
               data_in      = req_write_data;
               func_zero_in = (req_function_number == 3'd0);
               case (cmd)
                  CMD_READ: begin
                     is_read_in = 1'b1;
                     state_in   = ST_LOOK;
                  end
                  CMD_WRITE: begin
                     is_read_in = 1'b0;
                     state_in   = ST_LOOK;
                  end
                  CMD_RESET: begin
                     is_read_in   = 1'b0;
                     func_zero_in = 1'b1;
                     data_in      = 8'h00;
                     state_in     = ST_LOOK;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = 8'h00;
               rsp_mu_in    = 1'b0;
               rsp_seg_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               if (is_read_ff) begin
                  rsp_rd_in = func_zero_ff ? mem_rdata : OTHER_FUNC;
               end else if (func_zero_ff) begin
                  if (wr.shadow_we) begin
                     shadow_in = wr.shadow_val;
                  end
                  if (wr.count != 2'd0) begin
                     rsp_mu_in  = 1'b1;
                     rsp_seg_in = wr.seg0;
                  end
                  if (wr.count == 2'd2) begin
                     rsp_last_in = 1'b0;
                     pend_in     = wr.seg1;
                     state_in    = ST_SECOND;
                  end
               end
               rsp_shadow_in = (func_zero_ff && wr.shadow_we && !is_read_ff) ?
                               wr.shadow_val : shadow_ff;
            end
         end
         ST_SECOND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_rd_in     = 8'h00;
               rsp_mu_in     = 1'b1;
               rsp_seg_in    = pend_ff;
               rsp_shadow_in = shadow_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pam2_ff      <= 1'b0;
         shadow_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pam2_ff      <= pam2_in;
         shadow_ff    <= shadow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_read_ff    <= is_read_in;
      func_zero_ff  <= func_zero_in;
      addr_ff       <= addr_in;
      data_ff       <= data_in;
      pend_ff       <= pend_in;
      rsp_rd_ff     <= rsp_rd_in;
      rsp_mu_ff     <= rsp_mu_in;
      rsp_seg_ff    <= rsp_seg_in;
      rsp_shadow_ff <= rsp_shadow_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_rd_ff;
   assign rsp_map_update     = rsp_mu_ff;
   assign rsp_segment_base   = rsp_seg_ff.base;
   assign rsp_segment_size   = rsp_seg_ff.size;
   assign rsp_read_internal  = rsp_seg_ff.rd_int;
   assign rsp_write_internal = rsp_seg_ff.wr_int;
   assign rsp_shadow_bios    = rsp_shadow_ff;
   assign rsp_last           = rsp_last_ff;

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("config memory read and write in the same cycle");

   a_second_has_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SECOND) |-> rsp_valid_ff)
      else $error("second update pending without a first beat out");

   a_take_to_look: assert property (@(posedge clock) disable iff (reset)
      (req_take && (cmd == CMD_READ || cmd == CMD_WRITE || cmd == CMD_RESET))
      |=> (state_ff == ST_LOOK))
      else $error("request beat taken without a lookup");

   a_not_last_in_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff == ST_SECOND))
      else $error("non-final beat out with no second update pending");

endmodule
